// ===== rtl/core/wpm_pkg.sv =====
// wpm_pkg: constants, register codes and link types for the wildcard pattern matcher
// used by wpm_cell and wildcard_pattern_matcher_top; no dependencies
package wpm_pkg;

	localparam int PATTERN_MAX = 32;
	localparam int REG_BYTES   = 32;
	localparam int LEN_W       = 6;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 64;
	localparam int CHAR_W      = 8;
	localparam int POS_IDX_W   = $clog2(PATTERN_MAX + 1);

	localparam logic [CHAR_W-1:0] STAR_CHAR  = 8'h2A;
	localparam logic [CHAR_W-1:0] QUEST_CHAR = 8'h3F;
	localparam logic [CHAR_W-1:0] END_CHAR   = 8'h00;

	localparam logic [CFG_IDX_W-1:0] CFG_CHARS_A = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CHARS_B = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CHARS_C = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CHARS_D = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_LENGTH  = 3'd4;

	typedef struct packed {
		logic star_carry;
		logic advance;
	} cell_link_t;

endpackage

// ===== rtl/core/wpm_cell.sv =====
// wpm_cell: one pattern position of the matcher automaton, holds its live bit
// depends on wpm_pkg
module wpm_cell import wpm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [CHAR_W-1:0] pat_char,
	input  logic              active,
	input  logic              first,
	input  logic              step,
	input  logic              rearm,
	input  logic [CHAR_W-1:0] source_char,
	input  cell_link_t        link_in,
	output cell_link_t        link_out,
	output logic              closed,
	output logic              live
);

	// stored as live xor first so that reset clears every cell register
	logic live_q;
	logic is_star;
	logic hit;
	logic next_live;

	assign live     = live_q ^ first;
	assign is_star  = (pat_char == STAR_CHAR);
	assign hit      = (pat_char == QUEST_CHAR) || (pat_char == source_char);
	assign closed   = live | link_in.star_carry;

	assign link_out.star_carry = closed & active & is_star;
	assign link_out.advance    = closed & active & ~is_star & hit;

	always_comb begin
		if (rearm) begin
			next_live = first;
		end else begin
			next_live = (closed & active & is_star) | link_in.advance;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= 1'b0;
		end else if (step || rearm) begin
			live_q <= next_live ^ first;
		end
	end

endmodule

// ===== rtl/core/wildcard_pattern_matcher_top.sv =====
// Wildcard pattern matcher: takes one source byte per cycle on src, with no gaps needed
// between bytes or strings. Each pattern position is a cell holding one live bit; the star
// closure ripples along the row of 33 cells within the cycle and the live set updates in
// a single step as each byte is taken; the matched result is shown on res in the cycle after
// the terminator is taken. The src side stalls only while a result is held unread on res.
// A configuration write is taken every cycle and applies from the next byte on; it does not
// re-arm the automaton.
// depends on wpm_pkg and wpm_cell
module wildcard_pattern_matcher_top import wpm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  src_valid,
	output logic                  src_ready,
	input  logic [CHAR_W-1:0]     source_char,
	output logic                  res_valid,
	input  logic                  res_ready,
	output logic                  matched,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [3:0][CFG_DATA_W-1:0] pat_q;
	logic [LEN_W-1:0]           len_q;
	logic [LEN_W-1:0]           eff_len;
	logic                       res_valid_q;
	logic                       matched_q;
	logic                       src_fire;
	logic                       is_end;
	logic                       step;
	logic                       rearm;
	logic [PATTERN_MAX:0]       closed_vec;
	logic [PATTERN_MAX:0]       live_vec;
	cell_link_t                 links [0:PATTERN_MAX+1];

	assign cfg_ready = 1'b1;
	assign src_ready = ~res_valid_q | res_ready;
	assign src_fire  = src_valid & src_ready;
	assign is_end    = (source_char == END_CHAR);
	assign step      = src_fire & ~is_end;
	assign rearm     = src_fire & is_end;
	assign res_valid = res_valid_q;
	assign matched   = matched_q;

	assign eff_len = (len_q > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q <= '0;
			len_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_CHARS_A: pat_q[0] <= cfg_data;
				CFG_CHARS_B: pat_q[1] <= cfg_data;
				CFG_CHARS_C: pat_q[2] <= cfg_data;
				CFG_CHARS_D: pat_q[3] <= cfg_data;
				CFG_LENGTH:  len_q    <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign links[0] = '0;

	for (genvar g = 0; g <= PATTERN_MAX; g++) begin : g_cell
		logic [CHAR_W-1:0] cell_char;
		logic              cell_active;

		if (g < REG_BYTES) begin : g_byte
			assign cell_char = pat_q[g/8][(g%8)*CHAR_W +: CHAR_W];
		end else begin : g_zero
			assign cell_char = END_CHAR;
		end

		assign cell_active = (7'(g) < {1'b0, eff_len});

		wpm_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.pat_char    (cell_char),
			.active      (cell_active),
			.first       ((g == 0) ? 1'b1 : 1'b0),
			.step        (step),
			.rearm       (rearm),
			.source_char (source_char),
			.link_in     (links[g]),
			.link_out    (links[g+1]),
			.closed      (closed_vec[g]),
			.live        (live_vec[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (rearm) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rearm) begin
			matched_q <= closed_vec[eff_len[POS_IDX_W-1:0]];
		end
	end

	// terminator re-arms to position zero only
	a_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		rearm |=> (live_vec == {{PATTERN_MAX{1'b0}}, 1'b1}))
		else $error("live set not re-armed after terminator");

	// a byte never leaves a live position past the pattern end
	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> ((live_vec >> (7'($past(eff_len)) + 7'd1)) == '0))
		else $error("live position beyond pattern length");

	// a result appears only after a terminator item
	a_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(rearm))
		else $error("result without terminator");

	// a nonzero byte gives no result
	a_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(step && !res_valid_q) |=> !res_valid_q)
		else $error("result from a nonzero byte");

endmodule

// ===== bench/wildcard_pattern_matcher_top_tb.sv =====
// testbench for wildcard_pattern_matcher_top: streams source strings against configured
// glob patterns and checks each matched result against a bit-parallel live-set predictor
// depends on wpm_pkg and the wildcard_pattern_matcher_top rtl
`timescale 1ns / 1ps

module wildcard_pattern_matcher_top_tb;
	import wpm_pkg::*;

	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 2000;
	localparam int PHASES = 12;
	localparam int PHASE_ITEMS = 96;
	localparam logic [CHAR_W-1:0] LETTER_BASE = 8'h61;

	logic                  clk;
	logic                  arst_n;
	logic                  src_valid;
	logic                  src_ready;
	logic [CHAR_W-1:0]     source_char;
	logic                  res_valid;
	logic                  res_ready;
	logic                  matched;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// predictor state
	logic [REG_BYTES*CHAR_W-1:0] pat_bits = '0;
	logic [LEN_W-1:0]            pat_len = '0;
	logic [PATTERN_MAX:0]        live_set = 1;

	logic [CHAR_W-1:0] src_bytes[$];
	logic              match_due[$];

	int  sender_idle_pct = 0;
	int  recv_stall_pct = 0;
	bit  hold_req = 1'b0;
	bit  src_taken = 1'b0;
	int  fail_count = 0;
	int  stall_cycles = 0;

	wildcard_pattern_matcher_top u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.src_valid   (src_valid),
		.src_ready   (src_ready),
		.source_char (source_char),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.matched     (matched),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic void glob_step(input logic [CHAR_W-1:0] c);
		logic [PATTERN_MAX:0] cl;
		logic [PATTERN_MAX:0] nxt;
		logic [CHAR_W-1:0]    p;
		int                   n;
		n = (pat_len > PATTERN_MAX) ? PATTERN_MAX : int'(pat_len);
		cl = live_set;
		for (int i = 0; i < n; i++) begin
			if (cl[i] && pat_bits[i*CHAR_W +: CHAR_W] == STAR_CHAR)
				cl[i+1] = 1'b1;
		end
		if (c == END_CHAR) begin
			match_due.push_back(cl[n]);
			live_set = 1;
		end else begin
			nxt = '0;
			for (int i = 0; i < n; i++) begin
				if (cl[i]) begin
					p = pat_bits[i*CHAR_W +: CHAR_W];
					if (p == STAR_CHAR)
						nxt[i] = 1'b1;
					else if (p == QUEST_CHAR || p == c)
						nxt[i+1] = 1'b1;
				end
			end
			live_set = nxt;
		end
	endfunction

	function automatic logic [CHAR_W-1:0] rand_char();
		if ($urandom_range(99, 0) < 80)
			return LETTER_BASE + CHAR_W'($urandom_range(2, 0));
		return CHAR_W'($urandom_range(255, 1));
	endfunction

	function automatic logic [REG_BYTES*CHAR_W-1:0] rand_pattern(input int n);
		logic [REG_BYTES*CHAR_W-1:0] chars;
		int                          r;
		for (int k = 0; k < REG_BYTES / 4; k++)
			chars[k*32 +: 32] = $urandom;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99, 0);
			if (r < 25)
				chars[i*CHAR_W +: CHAR_W] = STAR_CHAR;
			else if (r < 40)
				chars[i*CHAR_W +: CHAR_W] = QUEST_CHAR;
			else if (r < 90)
				chars[i*CHAR_W +: CHAR_W] = LETTER_BASE + CHAR_W'($urandom_range(2, 0));
			else if (r < 96)
				chars[i*CHAR_W +: CHAR_W] = CHAR_W'($urandom_range(255, 1));
			else
				chars[i*CHAR_W +: CHAR_W] = END_CHAR;
		end
		return chars;
	endfunction

	// mostly strings built to fit the pattern, some with one edit, the rest noise
	function automatic int queue_string(input logic [REG_BYTES*CHAR_W-1:0] chars, input int n);
		logic [CHAR_W-1:0] s[$];
		logic [CHAR_W-1:0] b;
		int                r;
		int                pos;
		r = $urandom_range(99, 0);
		if (r < 70) begin
			for (int i = 0; i < n; i++) begin
				b = chars[i*CHAR_W +: CHAR_W];
				if (b == STAR_CHAR)
					repeat ($urandom_range(3, 0)) s.push_back(rand_char());
				else if (b == QUEST_CHAR || b == END_CHAR)
					s.push_back(rand_char());
				else
					s.push_back(b);
			end
			if (r >= 50) begin
				pos = $urandom_range(s.size(), 0);
				case ($urandom_range(2, 0))
					0: s.insert(pos, rand_char());
					1: if (pos < s.size()) s.delete(pos);
					default: if (pos < s.size()) s[pos] = rand_char();
				endcase
			end
		end else begin
			repeat ($urandom_range(8, 0)) s.push_back(rand_char());
		end
		foreach (s[i])
			src_bytes.push_back(s[i]);
		src_bytes.push_back(END_CHAR);
		return s.size() + 1;
	endfunction

	task automatic write_reg(input int idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_IDX_W'(idx);
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (CFG_IDX_W'(idx))
			CFG_CHARS_A, CFG_CHARS_B, CFG_CHARS_C, CFG_CHARS_D:
				pat_bits[(idx - CFG_CHARS_A)*CFG_DATA_W +: CFG_DATA_W] = data;
			CFG_LENGTH: pat_len = data[LEN_W-1:0];
			default: ;
		endcase
	endtask

	task automatic write_pattern(input logic [REG_BYTES*CHAR_W-1:0] chars,
			input logic [LEN_W-1:0] len);
		logic [CFG_DATA_W-1:0] data;
		for (int k = CFG_CHARS_A; k <= CFG_CHARS_D; k++)
			write_reg(k, chars[(k - CFG_CHARS_A)*CFG_DATA_W +: CFG_DATA_W]);
		data = {$urandom, $urandom};
		data[LEN_W-1:0] = len;
		write_reg(CFG_LENGTH, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (src_bytes.size() != 0 || match_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// source side
	always @(posedge clk) begin
		if (arst_n && src_valid && src_ready) begin
			glob_step(source_char);
			void'(src_bytes.pop_front());
			src_taken = 1'b1;
		end
	end

	always @(negedge clk) begin
		if (!src_valid || src_taken) begin
			if (src_bytes.size() != 0 && $urandom_range(99, 0) >= sender_idle_pct) begin
				src_valid <= 1'b1;
				source_char <= src_bytes[0];
			end else begin
				src_valid <= 1'b0;
			end
		end
		src_taken = 1'b0;
	end

	// result side
	always @(negedge clk) begin : res_drive
		int hold_left;
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_ready <= 1'b0;
		end else begin
			res_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin : res_check
		logic want;
		if (arst_n && res_valid && res_ready) begin
			if (match_due.size() == 0) begin
				if (fail_count < 10)
					$display("unexpected result: matched=%0b", matched);
				fail_count++;
			end else begin
				want = match_due.pop_front();
				if (matched !== want) begin
					if (fail_count < 10)
						$display("mismatch: expected matched=%0b, got %0b", want, matched);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((src_valid && src_ready) || (res_valid && res_ready) || (cfg_valid && cfg_ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		logic [REG_BYTES*CHAR_W-1:0] chars;
		int                          len;
		int                          count;
		arst_n = 1'b0;
		src_valid = 1'b0;
		source_char = '0;
		res_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty pattern matches only the empty string
		src_bytes = '{END_CHAR, LETTER_BASE, END_CHAR};
		wait_drained();

		// star, question, all-ones literal, trailing stars; question at end of string
		chars = '0;
		chars[39:0] = {STAR_CHAR, STAR_CHAR, 8'hFF, QUEST_CHAR, STAR_CHAR};
		write_pattern(chars, 5);
		src_bytes = '{8'h01, 8'hFF, END_CHAR, 8'hFF, END_CHAR};
		wait_drained();

		// length above the maximum, all stars
		chars = {REG_BYTES{STAR_CHAR}};
		write_pattern(chars, '1);
		src_bytes = '{8'h80, END_CHAR};
		wait_drained();

		// zero byte inside the pattern, dead automaton, length change mid-string
		chars = '0;
		chars[7:0] = LETTER_BASE;
		chars[23:16] = STAR_CHAR;
		write_pattern(chars, 3);
		src_bytes = '{LETTER_BASE, END_CHAR, LETTER_BASE + 8'd1, LETTER_BASE + 8'd2,
			LETTER_BASE, END_CHAR, LETTER_BASE};
		wait_drained();
		write_reg(CFG_LENGTH, 1);
		for (int k = CFG_LENGTH + 1; k < (1 << CFG_IDX_W); k++)
			write_reg(k, '1);
		@(negedge clk);
		cfg_valid <= 1'b0;
		src_bytes.push_back(END_CHAR);
		wait_drained();

		for (int p = 0; p < PHASES; p++) begin
			case (p % 4)
				0: begin sender_idle_pct = 0; recv_stall_pct = 0; end
				1: begin sender_idle_pct = 61; recv_stall_pct = 0; end
				2: begin sender_idle_pct = 0; recv_stall_pct = 61; end
				default: begin sender_idle_pct = 28; recv_stall_pct = 28; end
			endcase
			if (p == 0)
				len = PATTERN_MAX;
			else if (p == 1)
				len = (1 << LEN_W) - 1;
			else if (p == 2)
				len = 0;
			else if (p == 7)
				len = PATTERN_MAX + 1;
			else if ($urandom_range(9, 0) == 0)
				len = $urandom_range((1 << LEN_W) - 1, 0);
			else
				len = $urandom_range(12, 1);
			if (len > PATTERN_MAX)
				chars = rand_pattern(PATTERN_MAX);
			else
				chars = rand_pattern(len);
			write_pattern(chars, LEN_W'(len));
			if (p == 4)
				hold_req = 1'b1;
			count = 0;
			while (count < PHASE_ITEMS)
				count += queue_string(chars, (len > PATTERN_MAX) ? PATTERN_MAX : len);
			wait_drained();
		end

		fail_count += match_due.size();
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
